// File: rtl/pls_pkg.sv
// Shared types for the positional list store.
`default_nettype none

package pls_pkg;

	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int LEN_W = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_GET    = 2'd3
	} op_t;

	// Controller to datapath command for one accepted word.
	typedef struct packed {
		logic load;  // a word is accepted this cycle
		logic ins;   // write the item and shift the tail up
		logic app;   // the insert point is the end of the list
		logic del;   // shift the tail down over the removed cell
		logic rd;    // capture the cell at the requested position
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/pls_req_if.sv
// Request channel: opcode, position and item.
`default_nettype none

interface pls_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [4:0]  position;
	logic [31:0] item_value;

	modport source (output valid, output opcode, output position, output item_value,
		input ready);
	modport sink (input valid, input opcode, input position, input item_value,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pls_rsp_if.sv
// Response channel: outcome, read item, length and empty flag.
`default_nettype none

interface pls_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] read_value;
	logic [4:0]  length;
	logic        empty_res;

	modport source (output valid, output ok, output read_value, output length,
		output empty_res, input ready);
	modport sink (input valid, input ok, input read_value, input length,
		input empty_res, output ready);
endinterface

`default_nettype wire

// File: rtl/pls_ctrl.sv
// Controller: request checks, command issue and response holding.
`default_nettype none

module pls_ctrl #(
	parameter int DEPTH = 16,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [pls_pkg::POS_W-1:0] position,
	input  logic [CNT_W-1:0]     count,
	output pls_pkg::cmd_t        cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ok
);
	import pls_pkg::*;

	localparam int CW = (CNT_W + 1 > POS_W + 1) ? CNT_W + 1 : POS_W + 1;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t         state_q;
	logic           ok_q;
	logic           accept;
	logic           legal;
	logic           full;
	logic           pos_nz;
	logic [CW-1:0]  pos_w;
	logic [CW-1:0]  cnt_w;
	op_t            op;

	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);
	assign ok        = ok_q;

	always_comb begin
		op     = op_t'(opcode);
		pos_w  = CW'(position);
		cnt_w  = CW'(count);
		full   = (cnt_w == CW'(DEPTH));
		pos_nz = (position != '0);
		unique case (op)
			OP_APPEND: legal = !full;
			OP_INSERT: legal = !full && pos_nz && (pos_w <= cnt_w + CW'(1));
			OP_REMOVE: legal = pos_nz && (pos_w <= cnt_w);
			OP_GET:    legal = pos_nz && (pos_w <= cnt_w);
			default:   legal = 1'b0;
		endcase
		cmd.load = accept;
		cmd.ins  = accept && legal && ((op == OP_APPEND) || (op == OP_INSERT));
		cmd.app  = (op == OP_APPEND);
		cmd.del  = accept && legal && (op == OP_REMOVE);
		cmd.rd   = accept && legal && (op == OP_GET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HOLD;
						ok_q    <= legal;
					end
				end
				S_HOLD: begin
					if (accept) begin
						ok_q <= legal;
					end else if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/pls_dp.sv
// Datapath: shifting cell row, item count and read register.
`default_nettype none

module pls_dp #(
	parameter int DEPTH = 16,
	parameter int ITEM_WIDTH = 32,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pls_pkg::cmd_t             cmd,
	input  logic [pls_pkg::POS_W-1:0] position,
	input  logic [pls_pkg::VAL_W-1:0] item_value,
	output logic [CNT_W-1:0]          count,
	output logic [pls_pkg::VAL_W-1:0] read_value
);
	import pls_pkg::*;

	// Only the first 31 cells can be named by a position.
	localparam int RD_N = (DEPTH < 31) ? DEPTH : 31;

	logic [ITEM_WIDTH-1:0] slots_q [DEPTH];
	logic [CNT_W-1:0]      count_q;
	logic [VAL_W-1:0]      read_q;
	logic [IW-1:0]         idx;
	logic [ITEM_WIDTH-1:0] item;
	logic [ITEM_WIDTH-1:0] rd_cell;

	assign count      = count_q;
	assign read_value = read_q;
	assign item       = ITEM_WIDTH'(item_value);

	always_comb begin
		if (cmd.app) begin
			idx = count_q[IW-1:0];
		end else begin
			idx = IW'(POS_W'(position - POS_W'(1)));
		end
	end

	always_comb begin
		rd_cell = '0;
		for (int j = 0; j < RD_N; j++) begin
			if (position == POS_W'(j + 1)) begin
				rd_cell = slots_q[j];
			end
		end
	end

	// Each cell takes the item, its lower neighbor (insert) or its upper neighbor (remove).
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.ins) begin
				if (IW'(i) == idx) begin
					slots_q[i] <= item;
				end else if (i > 0 && IW'(i) > idx) begin
					slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.del) begin
				if (i < DEPTH - 1 && IW'(i) >= idx) begin
					slots_q[i] <= slots_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_q <= cmd.rd ? VAL_W'(rd_cell) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("item count above depth");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.del) && (!(cmd.ins || cmd.del || cmd.rd) || cmd.load))
		else $error("conflicting or unaccepted shift command");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> $stable(count_q))
		else $error("count moved without a request");

endmodule

`default_nettype wire

// File: rtl/positional_list_store_top.sv
// Positional list store: throughput one word per cycle while the response side keeps up.
// Latency: the response is valid in the cycle after the request is taken.
// The insert/remove shift over the whole cell row takes effect on the same clock edge as the response register.
// A new request is taken whenever no response waits or the waiting one leaves.
// Reset clears the item count and the response valid; cell contents are kept.
`default_nettype none

module positional_list_store_top #(
	parameter int DEPTH = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pls_req_if.sink   req,
	pls_rsp_if.source rsp
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             cmd;
	logic [CNT_W-1:0] count;
	logic             rsp_valid;
	logic             rsp_ok;
	logic             req_ready;
	logic [VAL_W-1:0] read_value;

	pls_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req_ready),
		.opcode    (req.opcode),
		.position  (req.position),
		.count     (count),
		.cmd       (cmd),
		.out_valid (rsp_valid),
		.out_ready (rsp.ready),
		.ok        (rsp_ok)
	);

	pls_dp #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.position   (req.position),
		.item_value (req.item_value),
		.count      (count),
		.read_value (read_value)
	);

	assign req.ready      = req_ready;
	assign rsp.valid      = rsp_valid;
	assign rsp.ok         = rsp_ok;
	assign rsp.read_value = read_value;
	assign rsp.length     = LEN_W'(count);
	assign rsp.empty_res  = (count == '0);

endmodule

`default_nettype wire

// File: tb/tb_positional_list_store_top.sv
`timescale 1ns / 1ps
// Testbench for the positional list store: directed and random requests against a list predictor.

module tb_positional_list_store_top;
	import pls_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS_PER_PHASE = 270;

	typedef struct {
		logic        ok;
		logic [31:0] read_value;
		logic [4:0]  length;
		logic        empty_res;
	} list_result_t;

	logic clk;
	logic arst_n;

	pls_req_if req_ch ();
	pls_rsp_if rsp_ch ();

	positional_list_store_top #(
		.DEPTH(LIST_DEPTH),
		.ITEM_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [31:0]  list_items[$];
	list_result_t pending_results[$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	int           src_idle_pct = 0;
	int           snk_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one request to the predicted list and return the result it should produce.
	function automatic list_result_t update_list(op_t op, logic [4:0] pos, logic [31:0] val);
		list_result_t res;
		int           len;
		len = list_items.size();
		res.ok = 1'b0;
		res.read_value = '0;
		case (op)
			OP_APPEND: begin
				if (len < LIST_DEPTH) begin
					list_items.push_back(val);
					res.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (len < LIST_DEPTH && pos >= 1 && pos <= len + 1) begin
					list_items.insert(pos - 1, val);
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos >= 1 && pos <= len) begin
					list_items.delete(pos - 1);
					res.ok = 1'b1;
				end
			end
			default: begin
				if (pos >= 1 && pos <= len) begin
					res.read_value = list_items[pos - 1];
					res.ok = 1'b1;
				end
			end
		endcase
		res.length = 5'(list_items.size());
		res.empty_res = (list_items.size() == 0);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Send one request word; return once it has been accepted.
	task automatic send_word(op_t op, logic [4:0] pos, logic [31:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.position <= pos;
		req_ch.item_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(update_list(op, pos, val));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_empty_list();
		send_word(OP_GET, 5'd1, 32'h0);
		send_word(OP_REMOVE, 5'd1, 32'hDEADBEEF);
		send_word(OP_INSERT, 5'd0, 32'h1111_1111);
		send_word(OP_INSERT, 5'd2, 32'h2222_2222);
	endtask

	task automatic test_positions();
		send_word(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
		send_word(OP_APPEND, 5'd31, 32'h0000_0000);
		send_word(OP_INSERT, 5'd2, 32'hA5A5_A5A5);
		send_word(OP_INSERT, 5'd4, 32'h5A5A_5A5A);
		send_word(OP_INSERT, 5'd6, 32'h1234_5678);
		send_word(OP_GET, 5'd0, 32'hFFFF_FFFF);
		send_word(OP_GET, 5'd1, 32'h0);
		send_word(OP_GET, 5'd5, 32'h0);
		send_word(OP_REMOVE, 5'd4, 32'h0);
		send_word(OP_REMOVE, 5'd1, 32'h0);
	endtask

	task automatic test_full_list();
		while (list_items.size() < LIST_DEPTH)
			send_word(OP_APPEND, 5'($urandom_range(31)), $urandom);
		send_word(OP_APPEND, 5'd0, $urandom);
		send_word(OP_INSERT, 5'd1, $urandom);
		send_word(OP_GET, 5'd16, $urandom);
		send_word(OP_GET, 5'd31, 32'h0);
		send_word(OP_REMOVE, 5'd16, 32'h0);
	endtask

	// Mostly legal positions for the current length, with fill and drain bursts
	// to reach the full and empty states, and some fully random words as noise.
	task automatic test_random_traffic(int n_items, int src_pct, int snk_pct, bit do_pause);
		op_t op;
		logic [4:0] pos;
		int len;
		int burst;
		burst = 0;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int i = 0; i < n_items; i++) begin
			len = list_items.size();
			if ((burst == 1 && len == LIST_DEPTH) || (burst == 2 && len == 0))
				burst = 0;
			else if (burst == 0 && $urandom_range(39) == 0)
				burst = $urandom_range(1, 2);
			if (do_pause && i == n_items / 2)
				wait_drained();
			if (burst == 1) begin
				op = ($urandom_range(1) != 0) ? OP_APPEND : OP_INSERT;
				pos = 5'($urandom_range(1, len + 1));
			end else if (burst == 2) begin
				op = OP_REMOVE;
				pos = 5'($urandom_range(1, len));
			end else if ($urandom_range(99) < 10) begin
				op = op_t'($urandom_range(3));
				pos = 5'($urandom_range(31));
			end else begin
				op = op_t'($urandom_range(3));
				case (op)
					OP_APPEND: pos = 5'($urandom_range(31));
					OP_INSERT: pos = 5'($urandom_range(1, len + 1));
					default: pos = (len == 0) ? 5'd1 : 5'($urandom_range(1, len));
				endcase
			end
			send_word(op, pos, $urandom);
		end
		wait_drained();
	endtask

	// Response checker
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("[%0t] result word with nothing expected", $time);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.ok !== want.ok)
					report_mismatch("ok", want.ok, rsp_ch.ok);
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch("read_value", want.read_value, rsp_ch.read_value);
				if (rsp_ch.length !== want.length)
					report_mismatch("length", want.length, rsp_ch.length);
				if (rsp_ch.empty_res !== want.empty_res)
					report_mismatch("empty_res", want.empty_res, rsp_ch.empty_res);
			end
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Watchdog: count cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_APPEND;
		req_ch.position = '0;
		req_ch.item_value = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_positions();
		test_full_list();
		wait_drained();

		test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 0, 1'b0);
		test_random_traffic(RANDOM_ITEMS_PER_PHASE, 87, 0, 1'b1);
		test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 87, 1'b0);
		test_random_traffic(RANDOM_ITEMS_PER_PHASE, 32, 32, 1'b0);

		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
